// ===== rtl/cbpc_pkg.sv =====
// Shared types and constants for the cursor blink and position controller.
package cbpc_pkg;

  localparam int unsigned CURSOR_LINES = 64;
  localparam logic [7:0]  DRAW_DELAY   = 8'd2;

  localparam int unsigned PIX_W  = 13;
  localparam int unsigned VS_W   = 14;
  localparam int unsigned IMG_W  = 22;
  localparam int unsigned BASE_W = 24;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_ERASE = 2'd1,
    CMD_DRAW  = 2'd2,
    CMD_MOVE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_BLINK_RATE  = 3'd0,
    REG_FONT_WIDTH  = 3'd1,
    REG_FONT_HEIGHT = 3'd2,
    REG_PAN_X       = 3'd3,
    REG_PAN_Y       = 3'd4,
    REG_BASE_OFFSET = 3'd5
  } reg_idx_e;

  // Words loaded into the position registers when the cursor is shown
  typedef struct packed {
    logic [IMG_W-1:0] image_offset;
    logic [VS_W-1:0]  vert_skip;
    logic [PIX_W-1:0] horz_skip;
    logic [PIX_W-1:0] posn_x;
    logic [PIX_W-1:0] posn_y;
  } shown_t;

endpackage

// ===== rtl/cursor_blink_position_controller_core.sv =====
// Cursor blink and position controller: top level with config, state and result register.
// Each request passes through the input register and then the result register.
// Throughput: one request per cycle while results are taken; the result register frees as its result is taken.
// Cell products are formed in the input stage; state update and clipping in the second.
// Reset: asynchronous active low; config returns to defaults, cursor state and shown words clear.
// No clearing pass: the block is ready for requests as soon as reset is released.
module cursor_blink_position_controller_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [2:0]                  cfg_index_i,
  input  logic [23:0]                 cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  cmd_i,
  input  logic [7:0]                  cell_col_i,
  input  logic [7:0]                  cell_row_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        cursor_shown_o,
  output logic [21:0]                 image_offset_o,
  output logic [13:0]                 vert_skip_o,
  output logic [12:0]                 horz_skip_o,
  output logic [12:0]                 posn_x_o,
  output logic [12:0]                 posn_y_o,
  output logic                        regs_written_o
);
  import cbpc_pkg::*;

  // configuration
  logic [7:0]        blink_rate_q;
  logic [5:0]        font_width_q;
  logic [6:0]        font_height_q;
  logic [PIX_W-1:0]  pan_x_q, pan_y_q;
  logic [BASE_W-1:0] base_offset_q;

  // input stage
  logic              s1_valid_q;
  cmd_e              s1_cmd_q;
  logic [PIX_W-1:0]  s1_nx_q, s1_ny_q;
  logic [13:0]       prod_x;
  logic [14:0]       prod_y;

  // cursor state
  logic [PIX_W-1:0]  pixel_x_q, pixel_x_d, pixel_y_q, pixel_y_d;
  logic              en_q, en_d, phase_q, phase_d;
  logic [7:0]        cnt_q, cnt_d, cnt_dec;
  shown_t            shown_q, shown_d, clip;
  logic              wrote_d, load, same;

  // result register
  logic              out_valid_q, out_wr_q, out_shown_q;

  logic adv, in_fire, s2_fire;

  assign cfg_ready_o = 1'b1;
  assign adv         = !out_valid_q || out_ready_i;
  assign in_ready_o  = !s1_valid_q || adv;
  assign in_fire     = in_valid_i && in_ready_o;
  assign s2_fire     = s1_valid_q && adv;

  assign prod_x = cell_col_i * font_width_q;
  assign prod_y = cell_row_i * font_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_rate_q  <= 8'd20;
      font_width_q  <= 6'd8;
      font_height_q <= 7'd16;
      pan_x_q       <= '0;
      pan_y_q       <= '0;
      base_offset_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_BLINK_RATE:  blink_rate_q  <= cfg_data_i[7:0];
        REG_FONT_WIDTH:  font_width_q  <= cfg_data_i[5:0];
        REG_FONT_HEIGHT: font_height_q <= cfg_data_i[6:0];
        REG_PAN_X:       pan_x_q       <= cfg_data_i[PIX_W-1:0];
        REG_PAN_Y:       pan_y_q       <= cfg_data_i[PIX_W-1:0];
        REG_BASE_OFFSET: base_offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cmd_q <= cmd_e'(cmd_i);
      s1_nx_q  <= prod_x[PIX_W-1:0];
      s1_ny_q  <= prod_y[PIX_W-1:0];
    end
  end

  logic is_erase;
  logic [PIX_W-1:0] clip_x, clip_y;

  assign is_erase = (s1_cmd_q == CMD_ERASE);
  assign same     = (s1_nx_q == pixel_x_q) && (s1_ny_q == pixel_y_q) && (is_erase == !en_q);
  assign cnt_dec  = cnt_q - 8'd1;
  // placement commands clip the new position, ticks the stored one
  assign clip_x   = (s1_cmd_q == CMD_TICK) ? pixel_x_q : s1_nx_q;
  assign clip_y   = (s1_cmd_q == CMD_TICK) ? pixel_y_q : s1_ny_q;

  cbpc_clip u_clip (
    .pixel_x_i     (clip_x),
    .pixel_y_i     (clip_y),
    .pan_x_i       (pan_x_q),
    .pan_y_i       (pan_y_q),
    .font_height_i (font_height_q),
    .base_offset_i (base_offset_q),
    .shown_o       (clip)
  );

  always_comb begin
    pixel_x_d = pixel_x_q;
    pixel_y_d = pixel_y_q;
    en_d      = en_q;
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    wrote_d   = 1'b0;
    load      = 1'b0;
    if (s1_cmd_q == CMD_TICK) begin
      if (en_q && (cnt_q != 8'd0)) begin
        cnt_d = cnt_dec;
        if (cnt_dec == 8'd0) begin
          phase_d = !phase_q;
          load    = !phase_q;
          wrote_d = 1'b1;
          cnt_d   = blink_rate_q;
        end
      end
    end else if (!same) begin
      en_d      = 1'b0;
      wrote_d   = phase_q;
      pixel_x_d = s1_nx_q;
      pixel_y_d = s1_ny_q;
      if (is_erase) begin
        phase_d = 1'b0;
      end else begin
        if (phase_q) load = 1'b1;
        else cnt_d = DRAW_DELAY;
        en_d = 1'b1;
      end
    end
    shown_d = load ? clip : shown_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_x_q   <= '0;
      pixel_y_q   <= '0;
      en_q        <= 1'b0;
      phase_q     <= 1'b0;
      cnt_q       <= '0;
      shown_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) out_valid_q <= s1_valid_q;
      if (s2_fire) begin
        pixel_x_q <= pixel_x_d;
        pixel_y_q <= pixel_y_d;
        en_q      <= en_d;
        phase_q   <= phase_d;
        cnt_q     <= cnt_d;
        shown_q   <= shown_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      out_wr_q    <= wrote_d;
      out_shown_q <= phase_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cursor_shown_o = out_shown_q;
  assign regs_written_o = out_wr_q;
  // shown words are only updated on a transfer, so they match the result register
  assign image_offset_o = shown_q.image_offset;
  assign vert_skip_o    = shown_q.vert_skip;
  assign horz_skip_o    = shown_q.horz_skip;
  assign posn_x_o       = shown_q.posn_x;
  assign posn_y_o       = shown_q.posn_y;

`ifndef SYNTHESIS
  a_phase_needs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> en_q)
    else $error("cursor visible while blinking disabled");

  a_idle_tick_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_fire && (s1_cmd_q == CMD_TICK) && !en_q) |=> !out_wr_q)
    else $error("tick while disabled wrote registers");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s1_valid_q) |-> adv)
    else $error("input register overwritten before transfer");

  a_shown_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s2_fire |=> $stable(shown_q))
    else $error("shown words changed without a transfer");
`endif

endmodule

// ===== rtl/cbpc_clip.sv =====
// Clips a cursor pixel position against the pan offsets and forms the register words.
module cbpc_clip (
  input  logic [cbpc_pkg::PIX_W-1:0]  pixel_x_i,
  input  logic [cbpc_pkg::PIX_W-1:0]  pixel_y_i,
  input  logic [cbpc_pkg::PIX_W-1:0]  pan_x_i,
  input  logic [cbpc_pkg::PIX_W-1:0]  pan_y_i,
  input  logic [6:0]                  font_height_i,
  input  logic [cbpc_pkg::BASE_W-1:0] base_offset_i,
  output cbpc_pkg::shown_t            shown_o
);
  import cbpc_pkg::*;

  logic             x_in, y_in;
  logic [PIX_W-1:0] ys;

  assign x_in = (pixel_x_i >= pan_x_i);
  assign y_in = (pixel_y_i >= pan_y_i);
  assign ys   = y_in ? '0 : (pan_y_i - pixel_y_i);

  always_comb begin
    shown_o.posn_x       = x_in ? (pixel_x_i - pan_x_i) : '0;
    shown_o.horz_skip    = x_in ? '0 : (pan_x_i - pixel_x_i);
    shown_o.posn_y       = y_in ? (pixel_y_i - pan_y_i) : '0;
    // overshoot counts in pairs of bytes per cursor line
    shown_o.image_offset = IMG_W'(base_offset_i[BASE_W-1:3]) + IMG_W'({ys, 1'b0});
    shown_o.vert_skip    = VS_W'(CURSOR_LINES) + VS_W'(ys) - VS_W'(font_height_i);
  end

endmodule

// ===== sim/cursor_blink_position_controller_core_tb.sv =====
// Testbench for the cursor blink and position controller: directed cases, then random requests.
`timescale 1ns / 100ps

module cursor_blink_position_controller_core_tb;
  import cbpc_pkg::*;

  typedef struct packed {
    logic        shown;
    logic [21:0] image_offset;
    logic [13:0] vert_skip;
    logic [12:0] horz_skip;
    logic [12:0] posn_x;
    logic [12:0] posn_y;
    logic        regs_written;
  } cursor_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [23:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  cmd_i;
  logic [7:0]  cell_col_i;
  logic [7:0]  cell_row_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        cursor_shown_o;
  logic [21:0] image_offset_o;
  logic [13:0] vert_skip_o;
  logic [12:0] horz_skip_o;
  logic [12:0] posn_x_o;
  logic [12:0] posn_y_o;
  logic        regs_written_o;

  cursor_blink_position_controller_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .cell_col_i     (cell_col_i),
    .cell_row_i     (cell_row_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cursor_shown_o (cursor_shown_o),
    .image_offset_o (image_offset_o),
    .vert_skip_o    (vert_skip_o),
    .horz_skip_o    (horz_skip_o),
    .posn_x_o       (posn_x_o),
    .posn_y_o       (posn_y_o),
    .regs_written_o (regs_written_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Predictor configuration
  logic [7:0]  blink_rate_r;
  logic [5:0]  font_w_r;
  logic [6:0]  font_h_r;
  logic [12:0] pan_x_r;
  logic [12:0] pan_y_r;
  logic [23:0] base_off_r;

  // Predictor cursor state
  logic [12:0] cur_px;
  logic [12:0] cur_py;
  logic        cur_blink_en;
  logic        cur_phase;
  logic [7:0]  cur_blink_cnt;
  shown_t      held_words;

  cursor_result_t pending_results[$];

  int unsigned mismatches;
  int unsigned requests_sent;
  int unsigned results_seen;
  int unsigned blink_toggles;
  int unsigned cfg_writes;
  bit          tx_steady;
  bit          rx_steady;

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Clip the cursor against the pan offsets and latch the shown words
  function automatic void load_shown_words();
    logic [12:0] x;
    logic [12:0] y;
    logic [12:0] xs;
    logic [12:0] ys;
    int unsigned img;
    int unsigned vs;
    x  = '0;
    y  = '0;
    xs = '0;
    ys = '0;
    if (cur_px >= pan_x_r) x = cur_px - pan_x_r;
    else xs = pan_x_r - cur_px;
    if (cur_py >= pan_y_r) y = cur_py - pan_y_r;
    else ys = pan_y_r - cur_py;
    img = (int'(base_off_r) >> 3) + 2 * int'(ys);
    // taller cursors wrap modulo 2^14
    vs  = CURSOR_LINES + int'(ys) - int'(font_h_r);
    held_words.image_offset = img[21:0];
    held_words.vert_skip    = vs[13:0];
    held_words.horz_skip    = xs;
    held_words.posn_x       = x;
    held_words.posn_y       = y;
  endfunction

  function automatic cursor_result_t advance_cursor(cmd_e cmd, logic [7:0] col,
                                                    logic [7:0] row);
    cursor_result_t res;
    logic           wrote;
    logic           is_erase;
    int unsigned    prod_x;
    int unsigned    prod_y;
    logic [12:0]    nx;
    logic [12:0]    ny;
    wrote = 1'b0;
    if (cmd == CMD_TICK) begin
      if (cur_blink_en && cur_blink_cnt != 8'd0) begin
        cur_blink_cnt = cur_blink_cnt - 8'd1;
        if (cur_blink_cnt == 8'd0) begin
          cur_phase = !cur_phase;
          if (cur_phase) load_shown_words();
          wrote         = 1'b1;
          cur_blink_cnt = blink_rate_r;
          blink_toggles++;
        end
      end
    end else begin
      prod_x   = int'(col) * int'(font_w_r);
      prod_y   = int'(row) * int'(font_h_r);
      nx       = prod_x[12:0];
      ny       = prod_y[12:0];
      is_erase = (cmd == CMD_ERASE);
      // same cell and already in the requested state: no effect
      if (!(nx == cur_px && ny == cur_py && is_erase == !cur_blink_en)) begin
        cur_blink_en = 1'b0;
        if (cur_phase) wrote = 1'b1;
        cur_px = nx;
        cur_py = ny;
        if (is_erase) begin
          cur_phase = 1'b0;
        end else begin
          if (cur_phase) load_shown_words();
          else cur_blink_cnt = DRAW_DELAY;
          cur_blink_en = 1'b1;
        end
      end
    end
    res.shown        = cur_phase;
    res.image_offset = held_words.image_offset;
    res.vert_skip    = held_words.vert_skip;
    res.horz_skip    = held_words.horz_skip;
    res.posn_x       = held_words.posn_x;
    res.posn_y       = held_words.posn_y;
    res.regs_written = wrote;
    return res;
  endfunction

  task automatic push_request(cmd_e cmd, logic [7:0] col, logic [7:0] row);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    cell_col_i <= col;
    cell_row_i <= row;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(advance_cursor(cmd, col, row));
    requests_sent++;
  endtask

  // Hold off new requests until every outstanding result is back
  task automatic drain_requests();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(reg_idx_e idx, logic [23:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_BLINK_RATE:  blink_rate_r = data[7:0];
      REG_FONT_WIDTH:  font_w_r     = data[5:0];
      REG_FONT_HEIGHT: font_h_r     = data[6:0];
      REG_PAN_X:       pan_x_r      = data[12:0];
      REG_PAN_Y:       pan_y_r      = data[12:0];
      REG_BASE_OFFSET: base_off_r   = data;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Defaults: idle tick, repeats, draw delay, redraw while shown, erase
  task automatic test_defaults();
    push_request(CMD_TICK, 8'hFF, 8'hFF);
    push_request(CMD_ERASE, 8'd0, 8'd0);
    push_request(CMD_DRAW, 8'd3, 8'd2);
    push_request(CMD_MOVE, 8'd3, 8'd2);
    push_request(CMD_TICK, 8'd0, 8'd0);
    push_request(CMD_TICK, 8'd0, 8'd0);
    push_request(CMD_DRAW, 8'd5, 8'd5);
    push_request(CMD_ERASE, 8'd5, 8'd5);
  endtask

  // Large fonts, largest pans and base; row product overflows 13 bits
  task automatic test_extremes();
    drain_requests();
    cfg_write(REG_BLINK_RATE, 24'd255);
    cfg_write(REG_FONT_WIDTH, 24'd32);
    cfg_write(REG_FONT_HEIGHT, 24'd64);
    cfg_write(REG_PAN_X, 24'd8191);
    cfg_write(REG_PAN_Y, 24'd8191);
    cfg_write(REG_BASE_OFFSET, 24'hFFFFFF);
    push_request(CMD_DRAW, 8'hFF, 8'hFF);
    push_request(CMD_TICK, 8'h00, 8'h00);
    push_request(CMD_TICK, 8'hAA, 8'h55);
    push_request(CMD_MOVE, 8'd0, 8'd0);
    push_request(CMD_ERASE, 8'd0, 8'd0);
    push_request(CMD_TICK, 8'd0, 8'd0);
    push_request(CMD_DRAW, 8'd0, 8'd0);
    push_request(CMD_TICK, 8'd0, 8'd0);
    push_request(CMD_TICK, 8'd0, 8'd0);
  endtask

  // Zero blink rate stops blinking; cursor taller than the sprite wraps vert_skip
  task automatic test_tall_no_blink();
    drain_requests();
    cfg_write(REG_BLINK_RATE, 24'd0);
    cfg_write(REG_FONT_WIDTH, 24'd1);
    cfg_write(REG_FONT_HEIGHT, 24'd100);
    cfg_write(REG_PAN_X, 24'd0);
    cfg_write(REG_PAN_Y, 24'd0);
    cfg_write(REG_BASE_OFFSET, 24'h000008);
    push_request(CMD_ERASE, 8'd0, 8'd0);
    push_request(CMD_DRAW, 8'd1, 8'd1);
    push_request(CMD_TICK, 8'd0, 8'd0);
    push_request(CMD_TICK, 8'd0, 8'd0);
    push_request(CMD_TICK, 8'd0, 8'd0);
    push_request(CMD_TICK, 8'd0, 8'd0);
    push_request(CMD_MOVE, 8'd2, 8'd3);
  endtask

  task automatic test_random(int unsigned phases, int unsigned per_phase);
    int unsigned pick;
    bit          wide;
    bit          near_cells;
    cmd_e        cmd;
    logic [7:0]  col;
    logic [7:0]  row;
    for (int unsigned p = 0; p < phases; p++) begin
      drain_requests();
      wide = ($urandom_range(0, 4) == 0);
      cfg_write(REG_BLINK_RATE, 24'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                                 : $urandom_range(0, 6)));
      cfg_write(REG_FONT_WIDTH, 24'(wide ? $urandom_range(0, 63) : $urandom_range(1, 32)));
      cfg_write(REG_FONT_HEIGHT, 24'(wide ? $urandom_range(0, 127) : $urandom_range(1, 64)));
      pick = $urandom_range(0, 2);
      cfg_write(REG_PAN_X, 24'((pick == 0) ? 0 : (pick == 1) ? $urandom_range(0, 255)
                                                             : $urandom_range(0, 8191)));
      pick = $urandom_range(0, 2);
      cfg_write(REG_PAN_Y, 24'((pick == 0) ? 0 : (pick == 1) ? $urandom_range(0, 255)
                                                             : $urandom_range(0, 8191)));
      cfg_write(REG_BASE_OFFSET, 24'($urandom_range(0, 24'hFFFFFF)));
      tx_steady  = ($urandom_range(0, 2) == 0);
      rx_steady  = ($urandom_range(0, 2) == 0);
      near_cells = ($urandom_range(0, 1) == 0);
      for (int unsigned i = 0; i < per_phase; i++) begin
        if (p % 3 == 1 && i == per_phase / 2) drain_requests();
        pick = $urandom_range(0, 99);
        if (pick < 55) cmd = CMD_TICK;
        else if (pick < 70) cmd = CMD_DRAW;
        else if (pick < 85) cmd = CMD_MOVE;
        else cmd = CMD_ERASE;
        // a small pool of cells makes repeated placements common
        if (near_cells && $urandom_range(0, 3) != 0) begin
          col = 8'($urandom_range(0, 3));
          row = 8'($urandom_range(0, 3));
        end else begin
          col = 8'($urandom_range(0, 255));
          row = 8'($urandom_range(0, 255));
        end
        push_request(cmd, col, row);
      end
    end
    drain_requests();
  endtask

  // Result side: random stall before each result is taken
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, 14);
      if (stall != 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin : result_check
    cursor_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding", 0, 0);
      end else begin
        want = pending_results.pop_front();
        if (cursor_shown_o !== want.shown)
          report_mismatch("cursor_shown", cursor_shown_o, want.shown);
        if (image_offset_o !== want.image_offset)
          report_mismatch("image_offset", image_offset_o, want.image_offset);
        if (vert_skip_o !== want.vert_skip)
          report_mismatch("vert_skip", vert_skip_o, want.vert_skip);
        if (horz_skip_o !== want.horz_skip)
          report_mismatch("horz_skip", horz_skip_o, want.horz_skip);
        if (posn_x_o !== want.posn_x)
          report_mismatch("posn_x", posn_x_o, want.posn_x);
        if (posn_y_o !== want.posn_y)
          report_mismatch("posn_y", posn_y_o, want.posn_y);
        if (regs_written_o !== want.regs_written)
          report_mismatch("regs_written", regs_written_o, want.regs_written);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    cmd_i         = CMD_TICK;
    cell_col_i    = '0;
    cell_row_i    = '0;
    blink_rate_r  = 8'd20;
    font_w_r      = 6'd8;
    font_h_r      = 7'd16;
    pan_x_r       = '0;
    pan_y_r       = '0;
    base_off_r    = '0;
    cur_px        = '0;
    cur_py        = '0;
    cur_blink_en  = 1'b0;
    cur_phase     = 1'b0;
    cur_blink_cnt = '0;
    held_words    = '0;
    mismatches    = 0;
    requests_sent = 0;
    results_seen  = 0;
    blink_toggles = 0;
    cfg_writes    = 0;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_defaults();
    test_extremes();
    test_tall_no_blink();
    test_random(13, 150);

    drain_requests();
    repeat (10) @(posedge clk_i);
    $display("Covered %0d requests and %0d results, %0d blink toggles, %0d register writes.",
             requests_sent, results_seen, blink_toggles, cfg_writes);
    $display("Included repeats, overflow, pan overshoot, tall cursor and zero blink rate.");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== cursor_blink_position_controller_core.f =====
rtl/cbpc_pkg.sv
rtl/cbpc_clip.sv
rtl/cursor_blink_position_controller_core.sv
sim/cursor_blink_position_controller_core_tb.sv
